// File: design/ssa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics package
// Shared widths, request codes, transaction structs and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned DIV_STEPS = ACC_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] average;
    logic [DATA_W-1:0] variance;
    logic [DATA_W-1:0] high_mark;
    logic [DATA_W-1:0] low_mark;
    logic [DATA_W-1:0] sample_total;
  } result_t;

  typedef struct packed {
    logic acc;
    logic clr;
    logic div_load;
    logic div_sel_sq;
    logic div_step;
    logic save_avg;
    logic mul;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage
`default_nettype wire

// File: design/ssa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics controller
// Decodes accepted transactions and sequences the two divisions, the square
// of the average and the result write for a read.
// ----------------------------------------------------------------------------
module ssa_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [ssa_pkg::REQ_W-1:0] req_type_i,
  input  wire ssa_pkg::dp_status_t      status_i,
  output ssa_pkg::ctrl_cmd_t            cmd_o,
  output logic                          busy_o
);
  import ssa_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV_A = 6'b000010,
    ST_SAVE_A = 6'b000100,
    ST_DIV_B = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (req_type_i)
            REQ_SAMPLE: cmd_o.acc = 1'b1;
            REQ_READ: begin
              cmd_o.div_load = 1'b1;
              state_d        = ST_DIV_A;
            end
            REQ_CLEAR: cmd_o.clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_DIV_A: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_SAVE_A;
      end
      ST_SAVE_A: begin
        cmd_o.save_avg   = 1'b1;
        cmd_o.div_load   = 1'b1;
        cmd_o.div_sel_sq = 1'b1;
        state_d          = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: design/ssa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics datapath
// Accumulators and water marks, a pipelined sample square, a one-bit-per-cycle
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module ssa_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [ssa_pkg::DATA_W-1:0] sample_i,
  input  wire ssa_pkg::ctrl_cmd_t        cmd_i,
  output ssa_pkg::dp_status_t            status_o,
  output logic                           result_valid_o,
  output ssa_pkg::result_t               result_o
);
  import ssa_pkg::*;

  logic [DATA_W-1:0]   count_q, low_q, high_q;
  logic [ACC_W-1:0]    sum_q, sumsq_q;
  logic [ACC_W-1:0]    sq_q;
  logic                sq_vld_q;
  logic [ACC_W-1:0]    sample_sq;

  logic [ACC_W-1:0]    dvd_q;
  logic [DATA_W-1:0]   rem_q;
  logic [STEP_W-1:0]   step_q;
  logic [DATA_W:0]     rem_sh;
  logic                q_bit;

  logic [DATA_W-1:0]   avg_q, q2_q, avgsq_q;
  logic [2*DATA_W-1:0] avg_prod;
  logic                result_valid_q;
  result_t             result_q;

  assign sample_sq = {{DATA_W{1'b0}}, sample_i} * {{DATA_W{1'b0}}, sample_i};
  assign avg_prod  = {{DATA_W{1'b0}}, avg_q} * {{DATA_W{1'b0}}, avg_q};

  assign rem_sh = {rem_q, dvd_q[ACC_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, count_q});

  assign status_o.div_last = (step_q == STEP_W'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      sumsq_q  <= '0;
      low_q    <= '1;
      high_q   <= '0;
      sq_vld_q <= 1'b0;
    end else if (cmd_i.clr) begin
      count_q  <= '0;
      sum_q    <= '0;
      sumsq_q  <= '0;
      low_q    <= '1;
      high_q   <= '0;
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= cmd_i.acc;
      if (sq_vld_q) sumsq_q <= sumsq_q + sq_q;
      if (cmd_i.acc) begin
        if (count_q != '1) count_q <= count_q + DATA_W'(1);
        sum_q <= sum_q + {{(ACC_W-DATA_W){1'b0}}, sample_i};
        if (sample_i < low_q) low_q <= sample_i;
        if (sample_i > high_q) high_q <= sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.emit;
      if (cmd_i.div_load) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) sq_q <= sample_sq;
    if (cmd_i.div_load) begin
      dvd_q <= cmd_i.div_sel_sq ? sumsq_q : sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[ACC_W-2:0], q_bit};
      rem_q <= q_bit ? DATA_W'(rem_sh - {1'b0, count_q}) : rem_sh[DATA_W-1:0];
    end
    if (cmd_i.save_avg) avg_q <= dvd_q[DATA_W-1:0];
    if (cmd_i.mul) begin
      q2_q    <= dvd_q[DATA_W-1:0];
      avgsq_q <= avg_prod[DATA_W-1:0];
    end
    if (cmd_i.emit) begin
      result_q.sample_total <= count_q;
      if (count_q == '0) begin
        result_q.average   <= '0;
        result_q.variance  <= '0;
        result_q.high_mark <= '0;
        result_q.low_mark  <= '0;
      end else begin
        result_q.average   <= avg_q;
        result_q.variance  <= q2_q - avgsq_q;
        result_q.high_mark <= high_q;
        result_q.low_mark  <= low_q;
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
`default_nettype wire

// File: design/sample_stats_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics accumulator
// Sample and clear transactions can be issued every cycle while busy is low.
// A read runs two 64-step bit-serial divisions on one shared divider, saving
// the average between them, then squares the average and writes the result;
// busy stays high until the result strobe. The receiver cannot stall the result.
// Reset is asynchronous and returns all statistics to their cleared values.
// ----------------------------------------------------------------------------
module sample_stats_accumulator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire ssa_pkg::req_t    req_i,
  output logic                  result_valid_o,
  output ssa_pkg::result_t      result_o
);
  import ssa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ssa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  ssa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (req_i.sample),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  a_no_back_to_back_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("Two result strobes in consecutive cycles.");

  a_read_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == REQ_READ) |=> busy)
    else $error("Read transaction did not make the block busy.");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("Result strobe without a preceding read sequence.");

  a_empty_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.sample_total == '0) |->
      (result_o.average == '0 && result_o.variance == '0 &&
       result_o.high_mark == '0 && result_o.low_mark == '0))
    else $error("Read with no samples returned nonzero statistics.");

endmodule
`default_nettype wire
